>>> rtl/core/opfb_pkg.sv
// Shared opcode type and link constants of the OLED page frame store.
`default_nettype none

package opfb_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_GLYPH = 2'd1,
    OP_EMIT  = 2'd2,
    OP_CMD   = 2'd3
  } op_t;

  localparam logic [6:0] CTRL_DATA = 7'h40;
  localparam logic [6:0] CTRL_CMD  = 7'h00;
  localparam int unsigned PAGE_ROWS = 8;

endpackage

`default_nettype wire

>>> rtl/core/oled_page_framebuffer_blit.sv
// Top level of the monochrome OLED page frame store with glyph-column blit.
`default_nettype none

// The frame store holds PAGE_COUNT pages of COLUMN_COUNT bytes in one memory with a single
// write port and a registered read port, so the block works on one word at a time. After
// reset, and after every clear word, the block walks the memory writing zeros, one byte per
// cycle, through all PAGE_COUNT*COLUMN_COUNT bytes, and takes no word meanwhile. A
// glyph-column write fills two pages when the pixel row is a multiple of eight and three
// pages otherwise, one byte per page touched. A glyph-column write whose column lies past
// the last is dropped in the cycle it is taken. An emit word reads the memory and a command
// word captures its byte; the output register is then loaded once it is free. The output
// register lets a new word be taken while an earlier result still waits to be delivered.
module oled_page_framebuffer_blit #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [6:0] column,
  input  wire logic [5:0] pixel_row,
  input  wire logic [7:0] upper_byte,
  input  wire logic [7:0] lower_byte,
  input  wire logic [7:0] command_byte,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic      [6:0] control_byte,
  output logic      [7:0] payload_byte,
  output logic            frame_last
);

  localparam int STORE_SIZE = PAGE_COUNT * COLUMN_COUNT;
  localparam int AW = $clog2(STORE_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_OUT
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] emit_pointer;
  logic [3:0] w_page;
  logic [6:0] w_col;
  logic [7:0] w_mid;
  logic [7:0] w_low;
  logic w_three;
  logic w_step;
  logic pend_emit;
  logic pend_last;
  logic [7:0] pend_cmd;

  logic accept;
  opfb_pkg::op_t op;
  logic col_ok;
  logic [23:0] shifted;
  logic [3:0] base_page;
  logic [3:0] step_page;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0] wr_data;
  logic rd_en;
  logic [7:0] rd_data;
  logic out_free;
  logic at_last;

  assign item_ready = (state == S_IDLE);
  assign accept = item_valid && item_ready;
  assign op = opfb_pkg::op_t'(opcode);
  assign col_ok = 32'(column) < COLUMN_COUNT;
  assign shifted = {8'd0, lower_byte, upper_byte} << pixel_row[2:0];
  assign base_page = {1'b0, pixel_row[5:3]};
  assign step_page = w_page + 4'd1 + {3'd0, w_step};
  assign out_free = !result_valid || result_ready;
  assign at_last = (emit_pointer == LAST_ADDR);
  assign rd_en = accept && (op == opfb_pkg::OP_EMIT);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = clr_addr;
    wr_data = 8'd0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        wr_en = accept && (op == opfb_pkg::OP_GLYPH) && col_ok &&
                (32'(base_page) < PAGE_COUNT);
        wr_addr = AW'(base_page) * AW'(COLUMN_COUNT) + AW'(column);
        wr_data = shifted[7:0];
      end
      S_WRITE: begin
        wr_en = 32'(step_page) < PAGE_COUNT;
        wr_addr = AW'(step_page) * AW'(COLUMN_COUNT) + AW'(w_col);
        wr_data = w_step ? w_low : w_mid;
      end
      S_OUT: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  opfb_ram #(
    .DEPTH(STORE_SIZE)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(emit_pointer),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      emit_pointer <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              opfb_pkg::OP_CLEAR: begin
                clr_addr <= '0;
                state <= S_CLEAR;
              end
              opfb_pkg::OP_GLYPH: begin
                w_page <= base_page;
                w_col <= column;
                w_mid <= shifted[15:8];
                w_low <= shifted[23:16];
                w_three <= (pixel_row[2:0] != 3'd0);
                w_step <= 1'b0;
                if (col_ok) begin
                  state <= S_WRITE;
                end
              end
              opfb_pkg::OP_EMIT: begin
                pend_emit <= 1'b1;
                pend_last <= at_last;
                emit_pointer <= at_last ? '0 : emit_pointer + AW'(1);
                state <= S_OUT;
              end
              opfb_pkg::OP_CMD: begin
                pend_emit <= 1'b0;
                pend_last <= 1'b0;
                pend_cmd <= command_byte;
                state <= S_OUT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_WRITE: begin
          if (w_three && !w_step) begin
            w_step <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            control_byte <= pend_emit ? opfb_pkg::CTRL_DATA : opfb_pkg::CTRL_CMD;
            payload_byte <= pend_emit ? rd_data : pend_cmd;
            frame_last <= pend_last;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && (op == opfb_pkg::OP_EMIT) && at_last |=> emit_pointer == '0)
    else $error("emit pointer did not wrap after the last byte");

  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    accept && (op == opfb_pkg::OP_CLEAR) |=> state == S_CLEAR && clr_addr == '0)
    else $error("clear word did not start a sweep from the first byte");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_OUT)
    else $error("result appeared without a pending word");

  a_no_read_in_write: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> state == S_IDLE && !(state == S_WRITE))
    else $error("memory read issued while a glyph write is in progress");

endmodule

`default_nettype wire

>>> rtl/core/opfb_ram.sv
// Byte-wide frame memory with one write port and one registered read port.
`default_nettype none

module opfb_ram #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
